[design/sitl_pkg.sv]
`timescale 1ns / 1ps
// package for the sector id table lookup: op codes, status codes, size modes, register indexes
package sitl_pkg;
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_APPEND = 3'd1;
    localparam logic [2:0] OP_SKIP   = 3'd2;
    localparam logic [2:0] OP_CHS    = 3'd3;
    localparam logic [2:0] OP_ABS    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_STOPPED  = 2'd3;

    localparam logic [1:0] SZ_DEFAULT = 2'd0;
    localparam logic [1:0] SZ_EXACT   = 2'd1;
    localparam logic [1:0] SZ_ANY     = 2'd2;

    localparam logic [2:0] REG_DEF_CODE = 3'd0;
    localparam logic [2:0] REG_SPT      = 3'd1;
    localparam logic [2:0] REG_HEADS    = 3'd2;
    localparam logic [2:0] REG_LIMIT    = 3'd3;
    localparam logic [2:0] REG_BASE     = 3'd4;
    localparam logic [2:0] REG_FILTER   = 3'd5;

    localparam logic [7:0]  ID_INVALID = 8'hFF;
    localparam logic [7:0]  CODE_MAX   = 8'd7;
    localparam logic [32:0] OFS_MAX    = {33{1'b1}};

    // one table entry: offset, cylinder, head, record, size code
    typedef struct packed {
        logic [31:0] ofs;
        logic [7:0]  cyl;
        logic [7:0]  head;
        logic [7:0]  rec;
        logic [2:0]  code;
    } t_entry;

    // 128 << code
    function automatic logic [14:0] code_bytes(input logic [2:0] code);
        code_bytes = 15'd128 << code;
    endfunction
endpackage

[design/sector_id_table_lookup.sv]
`timescale 1ns / 1ps
// sector id table: append, skip, clear and first-match lookup over a table memory
// Clear and append register their result at acceptance. A skip forms the product at
// acceptance; S_MUL then adds and saturates it, and S_DONE raises the result. A CHS
// lookup reads the table memory one entry per cycle. When the cylinder is not below
// the entry count, or the size request cannot match, the result is registered at
// acceptance. An absolute lookup first divides the sector number by sectors per track
// and then by the head count. The divider makes one quotient bit per cycle. The lookup
// then scans as above. One item is handled at a time. The next transaction is accepted
// once the held result is taken, in the same cycle at the earliest.
module sector_id_table_lookup
    import sitl_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_cylinder,
    input  logic [7:0]  i_head,
    input  logic [7:0]  i_record,
    input  logic [7:0]  i_size_code,
    input  logic [1:0]  i_size_mode,
    input  logic [15:0] i_sector_number,
    input  logic [7:0]  i_retry_count,
    input  logic [23:0] i_block_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_image_offset,
    output logic [14:0] o_sector_bytes,
    output logic [$clog2(MAX_ENTRIES + 1)-1:0] o_entry_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV1  = 3'd2;
    localparam logic [2:0] S_DIV2  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // configuration registers
    logic [2:0]  r_def_code;
    logic [7:0]  r_spt, r_heads;
    logic [31:0] r_limit, r_base;
    logic        r_filter;

    logic [2:0]  r_state;
    logic [CW-1:0] r_held;
    logic [32:0] r_next_ofs;
    logic        r_stopped;

    // request
    logic [7:0]  r_cyl, r_hd, r_rec;
    logic [2:0]  r_want;
    logic        r_any;
    logic [31:0] r_prod;

    // divider
    logic [15:0] r_quo, r_rem;
    logic [4:0]  r_bit;

    // scan
    logic [CW-1:0] r_idx;
    logic        r_rd_vld;
    logic        r_rd_last;
    t_entry      r_rd_data;

    // result
    logic        r_ovalid;
    logic [1:0]  r_status;
    logic [31:0] r_ofs;
    logic [14:0] r_bytes;

    // table memory
    t_entry      r_mem [MAX_ENTRIES];
    logic        mem_we;
    logic [AW-1:0] mem_wa;
    t_entry      mem_wd;

    logic in_acc, out_acc;
    assign o_ready     = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign in_acc      = i_valid && o_ready;
    assign out_acc     = r_ovalid && i_ready;
    assign o_cfg_ready = 1'b1;
    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_image_offset = r_ofs;
    assign o_sector_bytes = r_bytes;
    assign o_entry_count  = r_held;

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_code <= 3'd2;
            r_spt      <= 8'd0;
            r_heads    <= 8'd0;
            r_limit    <= 32'hFFFF_FFFF;
            r_base     <= 32'd288;
            r_filter   <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEF_CODE: r_def_code <= i_cfg_data[2:0];
                REG_SPT:      r_spt      <= i_cfg_data[7:0];
                REG_HEADS:    r_heads    <= i_cfg_data[7:0];
                REG_LIMIT:    r_limit    <= i_cfg_data;
                REG_BASE:     r_base     <= i_cfg_data;
                REG_FILTER:   r_filter   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // append decode
    logic        bad_id;
    logic [2:0]  app_code;
    logic [33:0] app_sum;
    logic [32:0] app_next;
    logic [31:0] sat_ofs;
    assign bad_id   = r_filter && (i_cylinder == ID_INVALID || i_head == ID_INVALID
                      || i_record == ID_INVALID || i_size_code > CODE_MAX);
    assign app_code = (i_size_code > CODE_MAX) ? 3'd7 : i_size_code[2:0];
    assign sat_ofs  = r_next_ofs[32] ? 32'hFFFF_FFFF : r_next_ofs[31:0];
    assign app_sum  = {1'b0, r_next_ofs} + 34'(code_bytes(app_code));
    assign app_next = app_sum[33] ? OFS_MAX : app_sum[32:0];
    assign mem_we = in_acc && i_op == OP_APPEND && !r_stopped && !bad_id
                    && r_held < CNT_MAX;
    assign mem_wa = r_held[AW-1:0];
    assign mem_wd = '{ofs: sat_ofs, cyl: i_cylinder, head: i_head,
                      rec: i_record, code: app_code};

    // skip sum
    logic [33:0] skip_sum;
    logic [32:0] skip_next;
    assign skip_sum  = {1'b0, r_next_ofs} + 34'(r_prod);
    assign skip_next = skip_sum[33] ? OFS_MAX : skip_sum[32:0];

    // restoring divide step: r_rem/r_quo shift, divisor chosen by phase
    logic [7:0]  div_d;
    logic [16:0] div_sh;
    logic        div_ge;
    assign div_d  = (r_state == S_DIV1) ? r_spt : r_heads;
    assign div_sh = {r_rem, r_quo[15]};
    assign div_ge = div_sh >= {9'd0, div_d};

    // scan compare on registered memory data
    logic hit;
    assign hit = r_rd_vld && r_rd_data.cyl == r_cyl && r_rd_data.head == r_hd
                 && r_rd_data.rec == r_rec && (r_any || r_rd_data.code == r_want);

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_held     <= '0;
            r_next_ofs <= 33'd288;
            r_stopped  <= 1'b0;
            r_ovalid   <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_rd_last  <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (out_acc) r_ovalid <= 1'b0;
            r_rd_vld <= 1'b0;
            case (r_state)
                S_IDLE: if (in_acc) begin
                    r_cyl   <= i_cylinder;
                    r_hd    <= i_head;
                    r_rec   <= i_record;
                    r_bytes <= 15'd0;
                    r_ofs   <= 32'd0;
                    r_ovalid <= 1'b1;
                    case (i_op)
                        OP_CLEAR: begin
                            r_held     <= '0;
                            r_next_ofs <= {1'b0, r_base};
                            r_stopped  <= 1'b0;
                            r_status   <= ST_OK;
                            r_ofs      <= r_base;
                        end
                        OP_APPEND: begin
                            if (r_stopped) begin
                                r_status <= ST_STOPPED;
                            end else if (bad_id) begin
                                r_status <= ST_OK;
                                r_ofs    <= sat_ofs;
                            end else if (r_held >= CNT_MAX) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_held     <= r_held + 1'b1;
                                r_next_ofs <= app_next;
                                if (app_next > {1'b0, r_limit}) r_stopped <= 1'b1;
                                r_status <= ST_OK;
                                r_ofs    <= sat_ofs;
                                r_bytes  <= code_bytes(app_code);
                            end
                        end
                        OP_SKIP: begin
                            if (r_stopped) begin
                                r_status <= ST_STOPPED;
                            end else begin
                                r_ovalid <= 1'b0;
                                r_state  <= S_MUL;
                                r_prod   <= 32'({1'b0, i_retry_count} + 9'd1)
                                            * 32'(i_block_length);
                            end
                        end
                        OP_CHS: begin
                            r_status <= ST_NOTFOUND;
                            r_any    <= i_size_mode == SZ_ANY;
                            r_want   <= (i_size_mode == SZ_EXACT) ? i_size_code[2:0]
                                                                  : r_def_code;
                            if (!(i_size_mode == SZ_DEFAULT || i_size_mode == SZ_ANY
                                  || (i_size_mode == SZ_EXACT
                                      && i_size_code <= CODE_MAX))
                                || {{(CW > 8 ? CW-8 : 0){1'b0}}, i_cylinder} >= r_held
                                   && CW >= 8
                                || (CW < 8 && i_cylinder >= 8'(r_held))) begin
                                r_status <= ST_NOTFOUND;
                            end else begin
                                r_ovalid <= 1'b0;
                                r_idx    <= '0;
                                r_state  <= S_SCAN;
                            end
                        end
                        OP_ABS: begin
                            r_status <= ST_NOTFOUND;
                            r_any    <= 1'b0;
                            r_want   <= r_def_code;
                            if (r_spt != 8'd0 && r_heads != 8'd0) begin
                                r_ovalid <= 1'b0;
                                r_quo    <= i_sector_number;
                                r_rem    <= 16'd0;
                                r_bit    <= 5'd0;
                                r_state  <= S_DIV1;
                            end
                        end
                        default: r_status <= ST_NOTFOUND;
                    endcase
                end
                S_MUL: begin
                    r_next_ofs <= skip_next;
                    r_status   <= ST_OK;
                    r_ofs      <= skip_next[32] ? 32'hFFFF_FFFF : skip_next[31:0];
                    r_state    <= S_DONE;
                end
                S_DIV1, S_DIV2: begin
                    r_quo <= {r_quo[14:0], div_ge};
                    r_rem <= div_ge ? 16'(div_sh - {9'd0, div_d}) : div_sh[15:0];
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == 5'd15) begin
                        r_bit <= 5'd0;
                        if (r_state == S_DIV1) begin
                            // record from remainder, restart on the quotient
                            r_rec   <= 8'((div_ge ? 16'(div_sh - {9'd0, div_d})
                                          : div_sh[15:0]) + 16'd1);
                            r_quo   <= {r_quo[14:0], div_ge};
                            r_rem   <= 16'd0;
                            r_state <= S_DIV2;
                        end else begin
                            r_hd  <= 8'(div_ge ? 16'(div_sh - {9'd0, div_d})
                                        : div_sh[15:0]);
                            r_cyl <= r_quo[6:0] == 7'd0 && !div_ge ? 8'd0
                                     : {r_quo[6:0], div_ge};
                            r_idx <= '0;
                            r_state <= S_SCAN;
                            // cylinder bound checked on entry to scan below
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx == '0 && !r_rd_vld && !r_rd_last
                        && CW'(r_cyl) >= r_held && CW > 8) begin
                        r_status <= ST_NOTFOUND;
                        r_state  <= S_DONE;
                    end else if (r_idx == '0 && !r_rd_vld && !r_rd_last && CW <= 8
                                 && r_cyl >= 8'(r_held)) begin
                        r_status <= ST_NOTFOUND;
                        r_state  <= S_DONE;
                    end else if (hit) begin
                        r_status <= ST_OK;
                        r_ofs    <= r_rd_data.ofs;
                        r_bytes  <= code_bytes(r_rd_data.code);
                        r_rd_last <= 1'b0;
                        r_idx    <= '0;
                        r_state  <= S_DONE;
                    end else if (r_rd_vld && r_rd_last) begin
                        r_status <= ST_NOTFOUND;
                        r_rd_last <= 1'b0;
                        r_idx    <= '0;
                        r_state  <= S_DONE;
                    end else if (!r_rd_last) begin
                        r_rd_vld  <= 1'b1;
                        r_rd_last <= (r_idx + 1'b1) == r_held;
                        r_idx     <= r_idx + 1'b1;
                    end
                end
                S_DONE: if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // held count never exceeds the table depth
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_MAX) else $error("entry count above table depth");
    // a table write only happens on an accepted transaction
    a_we_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> in_acc) else $error("table written outside a transaction");
    // no input accepted while a multi-cycle op is in progress
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    // append grows count by one
    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_held == $past(r_held) + 1'b1) else $error("append count slip");
endmodule
